// ===== hdl/trip_fuel_distance_accumulator_top_assert.svh =====
// assertion macros for the trip fuel and distance accumulator checker
`ifndef TRIP_FUEL_DISTANCE_ACCUMULATOR_TOP_ASSERT_SVH
`define TRIP_FUEL_DISTANCE_ACCUMULATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TFDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define TFDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tfda_pkg.sv =====
// types and constants shared by the trip fuel and distance accumulator
package tfda_pkg;

  localparam int unsigned SlotCount = 3;
  localparam int unsigned SumW      = 32;
  localparam int unsigned PctW      = 8;

  // shared multiplier
  localparam int unsigned MulW  = 25;
  localparam int unsigned ProdW = 2 * MulW;

  // exact reciprocals: floor(x / d) == (x * m) >> k over the dividend range
  localparam logic [MulW-1:0] Recip36   = 25'd29826162;  // x < 2^24
  localparam int unsigned     Shift36   = 30;
  localparam logic [MulW-1:0] Recip100  = 25'd21474837;  // x < 2^24
  localparam int unsigned     Shift100  = 31;
  localparam logic [34:0]     Recip1073 = 35'd32790654324;  // x < 2^34
  localparam int unsigned     Shift1073 = 45;

  // the 34 x 35 bit fuel divide is split at bit 17 into 17 and 18 bit slices
  localparam int unsigned SplitW = 17;
  localparam int unsigned XW     = 2 * SplitW;
  localparam int unsigned AccW   = 69;
  localparam logic [SplitW-1:0]   RecipLo = Recip1073[SplitW-1:0];
  localparam logic [34-SplitW:0]  RecipHi = Recip1073[34:SplitW];

  localparam int unsigned DistIncW = 19;
  localparam int unsigned FlowW    = 18;
  localparam int unsigned FuelIncW = 24;

  localparam logic [15:0]     OpenLoopMask = 16'h0400;
  localparam logic [8:0]      IdleMargin   = 9'd4;
  localparam logic [7:0]      IdleReset    = 8'd255;
  localparam logic [PctW-1:0] PctReset     = 8'd100;

  typedef struct packed {
    logic [2:0]  clear_trip_mask;
    logic [15:0] elapsed_ms;
    logic        speed_valid;
    logic [7:0]  speed_kmh;
    logic        engine_running;
    logic        throttle_valid;
    logic [7:0]  throttle_raw;
    logic        status_valid;
    logic [15:0] status_word;
    logic        flow_supported;
    logic        flow_valid;
    logic [15:0] flow_raw;
  } in_item_t;

  typedef struct packed {
    logic [31:0] tank_distance;
    logic [31:0] tank_burn;
    logic [31:0] tank_idle_burn;
    logic [31:0] trip_distance;
    logic [31:0] trip_burn;
    logic [31:0] trip_idle_burn;
    logic [31:0] outing_distance;
    logic [31:0] outing_burn;
    logic [31:0] outing_idle_burn;
    logic [31:0] adjusted_flow;
    logic [7:0]  idle_throttle;
  } out_item_t;

  typedef struct packed {
    logic [SlotCount-1:0] clr_mask;
    logic                 dist_en;
    logic                 fuel_en;
    logic                 waste_en;
  } bank_cmd_t;

endpackage

// ===== hdl/trip_fuel_distance_accumulator_top.sv =====
// trip fuel and distance accumulator top level with step sequencer
// One sample item is taken at a time and worked on in full before the next
// is accepted. An item with an invalid speed reading goes straight to the
// output step; others run the distance multiply, divide and add and then the
// engine, throttle, status and fuel cut-off checks, and on the full fuel
// path flow times gain, divide by 100, flow times time, divide by 1073 and
// fuel add. The single 25 x 25 bit registered multiplier forms speed times
// time, both constant divides by reciprocal, flow times gain and flow times
// time, and the four partial products of the divide by 1073. A finished
// result waits in the output register while the next item is accepted and
// worked on; an item that finishes while that result is still waiting holds
// in its last step until the result is taken. The gain register port is
// always ready and unguarded; the user must write it with no item in flight.
module trip_fuel_distance_accumulator_top #(
  parameter int unsigned TRIP_COUNT = 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tfda_pkg::PctW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  tfda_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tfda_pkg::out_item_t       out_data_o
);
  import tfda_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_D_MUL,
    S_D_DIV,
    S_D_ADD,
    S_CHECK,
    S_F_DIV,
    S_F_MUL,
    S_R0,
    S_R1,
    S_R2,
    S_R3,
    S_R4,
    S_F_ADD,
    S_DONE
  } state_e;

  state_e          state_q, state_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;
  logic [7:0]      idle_q, idle_d;
  logic [PctW-1:0] pct_q, pct_d;

  in_item_t        item_q, item_d;
  logic [FlowW-1:0] flow_q, flow_d;
  logic [XW-1:0]   x_q, x_d;
  logic [AccW-1:0] acc_q, acc_d;

  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] mul_p;

  bank_cmd_t            cmd;
  logic [DistIncW-1:0]  dist_inc;
  logic [FuelIncW-1:0]  fuel_inc;
  logic [SumW-1:0]      dist_sum  [TRIP_COUNT];
  logic [SumW-1:0]      fuel_sum  [TRIP_COUNT];
  logic [SumW-1:0]      waste_sum [TRIP_COUNT];
  logic [SumW-1:0]      slot_dist  [SlotCount];
  logic [SumW-1:0]      slot_fuel  [SlotCount];
  logic [SumW-1:0]      slot_waste [SlotCount];

  logic [7:0]       idle_new;
  logic             cutoff;
  logic [15:0]      flow_eff;
  logic [FlowW-1:0] flow_now;

  tfda_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  tfda_bank #(
    .TRIP_COUNT (TRIP_COUNT)
  ) u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .dist_inc_i  (dist_inc),
    .fuel_inc_i  (fuel_inc),
    .dist_sum_o  (dist_sum),
    .fuel_sum_o  (fuel_sum),
    .waste_sum_o (waste_sum)
  );

  // trips beyond the configured count read as zero
  for (genvar s = 0; s < SlotCount; s++) begin : g_slot
    if (s < TRIP_COUNT) begin : g_used
      assign slot_dist[s]  = dist_sum[s];
      assign slot_fuel[s]  = fuel_sum[s];
      assign slot_waste[s] = waste_sum[s];
    end else begin : g_unused
      assign slot_dist[s]  = '0;
      assign slot_fuel[s]  = '0;
      assign slot_waste[s] = '0;
    end
  end

  assign dist_inc = mul_p[Shift36 +: DistIncW];
  assign fuel_inc = acc_q[Shift1073 +: FuelIncW];
  assign flow_now = mul_p[Shift100 +: FlowW];

  assign idle_new = (item_q.throttle_raw != 8'd0 && item_q.throttle_raw < idle_q) ?
                    item_q.throttle_raw : idle_q;
  // overrun cut-off: throttle near idle while in open loop
  assign cutoff   = ({1'b0, item_q.throttle_raw} < ({1'b0, idle_new} + IdleMargin)) &&
                    ((item_q.status_word & OpenLoopMask) != 16'd0);
  assign flow_eff = (item_q.flow_supported && item_q.flow_valid) ? item_q.flow_raw : 16'd0;

  assign pct_d = (cfg_valid_i) ? cfg_data_i : pct_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    idle_d      = idle_q;
    item_d      = item_q;
    flow_d      = flow_q;
    x_d         = x_q;
    acc_d       = acc_q;
    mul_a       = '0;
    mul_b       = '0;
    cmd         = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d       = in_data_i;
          flow_d       = '0;
          cmd.clr_mask = in_data_i.clear_trip_mask;
          state_d      = in_data_i.speed_valid ? S_D_MUL : S_DONE;
        end
      end
      S_D_MUL: begin
        mul_a   = MulW'(item_q.speed_kmh);
        mul_b   = MulW'(item_q.elapsed_ms);
        state_d = S_D_DIV;
      end
      S_D_DIV: begin
        mul_a   = mul_p[MulW-1:0];
        mul_b   = Recip36;
        state_d = S_D_ADD;
      end
      S_D_ADD: begin
        cmd.dist_en = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        if (!item_q.engine_running || !item_q.throttle_valid) begin
          state_d = S_DONE;
        end else begin
          idle_d = idle_new;
          if (!item_q.status_valid || cutoff) begin
            state_d = S_DONE;
          end else begin
            mul_a   = MulW'(flow_eff);
            mul_b   = MulW'(pct_q);
            state_d = S_F_DIV;
          end
        end
      end
      S_F_DIV: begin
        mul_a   = mul_p[MulW-1:0];
        mul_b   = Recip100;
        state_d = S_F_MUL;
      end
      S_F_MUL: begin
        flow_d  = flow_now;
        mul_a   = MulW'(flow_now);
        mul_b   = MulW'(item_q.elapsed_ms);
        state_d = S_R0;
      end
      // fuel divide: low x low, two cross terms, high x high
      S_R0: begin
        x_d     = mul_p[XW-1:0];
        mul_a   = MulW'(mul_p[SplitW-1:0]);
        mul_b   = MulW'(RecipLo);
        state_d = S_R1;
      end
      S_R1: begin
        acc_d   = AccW'(mul_p);
        mul_a   = MulW'(x_q[SplitW-1:0]);
        mul_b   = MulW'(RecipHi);
        state_d = S_R2;
      end
      S_R2: begin
        acc_d   = acc_q + (AccW'(mul_p) << SplitW);
        mul_a   = MulW'(x_q[XW-1:SplitW]);
        mul_b   = MulW'(RecipLo);
        state_d = S_R3;
      end
      S_R3: begin
        acc_d   = acc_q + (AccW'(mul_p) << SplitW);
        mul_a   = MulW'(x_q[XW-1:SplitW]);
        mul_b   = MulW'(RecipHi);
        state_d = S_R4;
      end
      S_R4: begin
        acc_d   = acc_q + (AccW'(mul_p) << XW);
        state_d = S_F_ADD;
      end
      S_F_ADD: begin
        cmd.fuel_en  = 1'b1;
        cmd.waste_en = (item_q.speed_kmh == 8'd0);
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_d.tank_distance    = slot_dist[0];
          out_d.tank_burn        = slot_fuel[0];
          out_d.tank_idle_burn   = slot_waste[0];
          out_d.trip_distance    = slot_dist[1];
          out_d.trip_burn        = slot_fuel[1];
          out_d.trip_idle_burn   = slot_waste[1];
          out_d.outing_distance  = slot_dist[2];
          out_d.outing_burn      = slot_fuel[2];
          out_d.outing_idle_burn = slot_waste[2];
          out_d.adjusted_flow    = 32'(flow_q);
          out_d.idle_throttle    = idle_q;
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      idle_q      <= IdleReset;
      pct_q       <= PctReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      idle_q      <= idle_d;
      pct_q       <= pct_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    flow_q <= flow_d;
    x_q    <= x_d;
    acc_q  <= acc_d;
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/tfda_mul.sv =====
// shared unsigned multiplier with registered product
module tfda_mul (
  input  logic                        clk_i,
  input  logic [tfda_pkg::MulW-1:0]   a_i,
  input  logic [tfda_pkg::MulW-1:0]   b_i,
  output logic [tfda_pkg::ProdW-1:0]  p_o
);
  import tfda_pkg::*;

  logic [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== hdl/tfda_bank.sv =====
// per-trip distance, fuel and waste sums
module tfda_bank #(
  parameter int unsigned TRIP_COUNT = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tfda_pkg::bank_cmd_t           cmd_i,
  input  logic [tfda_pkg::DistIncW-1:0] dist_inc_i,
  input  logic [tfda_pkg::FuelIncW-1:0] fuel_inc_i,
  output logic [tfda_pkg::SumW-1:0]     dist_sum_o  [TRIP_COUNT],
  output logic [tfda_pkg::SumW-1:0]     fuel_sum_o  [TRIP_COUNT],
  output logic [tfda_pkg::SumW-1:0]     waste_sum_o [TRIP_COUNT]
);
  import tfda_pkg::*;

  logic [SumW-1:0] dist_q  [TRIP_COUNT];
  logic [SumW-1:0] fuel_q  [TRIP_COUNT];
  logic [SumW-1:0] waste_q [TRIP_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TRIP_COUNT; i++) begin
        dist_q[i]  <= '0;
        fuel_q[i]  <= '0;
        waste_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < TRIP_COUNT; i++) begin
        if (cmd_i.clr_mask[i]) begin
          dist_q[i]  <= '0;
          fuel_q[i]  <= '0;
          waste_q[i] <= '0;
        end else begin
          if (cmd_i.dist_en) begin
            dist_q[i] <= dist_q[i] + SumW'(dist_inc_i);
          end
          if (cmd_i.fuel_en) begin
            fuel_q[i] <= fuel_q[i] + SumW'(fuel_inc_i);
          end
          if (cmd_i.waste_en) begin
            waste_q[i] <= waste_q[i] + SumW'(fuel_inc_i);
          end
        end
      end
    end
  end

  assign dist_sum_o  = dist_q;
  assign fuel_sum_o  = fuel_q;
  assign waste_sum_o = waste_q;

endmodule

// ===== hdl/tfda_checker.sv =====
// port-level checks for the trip fuel and distance accumulator
`include "trip_fuel_distance_accumulator_top_assert.svh"

module tfda_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tfda_pkg::out_item_t out_data_o
);
  import tfda_pkg::*;

  // a waiting result holds until taken
  `TFDA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")

  // one item at a time: busy right after an item is taken
  `TFDA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "input ready right after acceptance")

  // idle position only ever takes nonzero throttle values
  `TFDA_ASSERT_NOW(a_idle_nonzero, out_valid_o, out_data_o.idle_throttle != 8'd0, "idle throttle is zero")

  // flow after gain cannot exceed 65535 * 255 / 100
  `TFDA_ASSERT_NOW(a_flow_range, out_valid_o, (out_data_o.adjusted_flow >> FlowW) == 32'd0, "adjusted flow out of range")

endmodule

bind trip_fuel_distance_accumulator_top tfda_checker u_tfda_checker (.*);

// ===== tb/tb_trip_fuel_distance_accumulator_top.sv =====
// testbench for the trip fuel and distance accumulator: directed, gain, wrap and random checks
`timescale 1ns / 1ps

module tb_trip_fuel_distance_accumulator_top;
  import tfda_pkg::*;

  localparam int unsigned TripCount  = 3;
  localparam int unsigned CycleLimit = 1_200_000;
  localparam int unsigned BlockLatency = 16;
  localparam longint unsigned DistDiv = 36;
  localparam longint unsigned PctDiv  = 100;
  localparam longint unsigned FuelDiv = 1073;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [PctW-1:0] cfg_data_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;

  // predictor state
  logic [31:0] distance_sum [TripCount];
  logic [31:0] fuel_sum [TripCount];
  logic [31:0] waste_sum [TripCount];
  logic [7:0]  idle_pos;
  logic [7:0]  gain_pct;

  out_item_t   pending_totals [$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;

  trip_fuel_distance_accumulator_top #(
    .TRIP_COUNT(TripCount)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("trip_fuel_distance_accumulator_top test failed");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // applies one sample to the trip sums and returns the totals it produces
  function automatic out_item_t accumulate_sample(in_item_t s);
    out_item_t r;
    longint unsigned dist_inc;
    longint unsigned flow;
    longint unsigned fuel_inc;
    logic [8:0] idle_limit;
    bit cut_off;
    flow = 0;
    for (int i = 0; i < TripCount; i++) begin
      if (s.clear_trip_mask[i]) begin
        distance_sum[i] = '0;
        fuel_sum[i] = '0;
        waste_sum[i] = '0;
      end
    end
    if (s.speed_valid) begin
      if (s.speed_kmh != 0) begin
        dist_inc = (64'(s.speed_kmh) * 64'(s.elapsed_ms)) / DistDiv;
        for (int i = 0; i < TripCount; i++) distance_sum[i] += dist_inc[31:0];
      end
      if (s.engine_running && s.throttle_valid) begin
        if (s.throttle_raw != 0 && s.throttle_raw < idle_pos) idle_pos = s.throttle_raw;
        if (s.status_valid) begin
          // idle margin is formed one bit wider so 255 + 4 does not wrap
          idle_limit = {1'b0, idle_pos} + 9'd4;
          cut_off = ({1'b0, s.throttle_raw} < idle_limit) &&
                    ((s.status_word & OpenLoopMask) != 0);
          if (!cut_off) begin
            flow = (s.flow_supported && s.flow_valid) ? 64'(s.flow_raw) : 64'd0;
            flow = (flow * 64'(gain_pct)) / PctDiv;
            fuel_inc = (flow * 64'(s.elapsed_ms)) / FuelDiv;
            for (int i = 0; i < TripCount; i++) begin
              fuel_sum[i] += fuel_inc[31:0];
              if (s.speed_kmh == 0) waste_sum[i] += fuel_inc[31:0];
            end
          end
        end
      end
    end
    r.tank_distance    = distance_sum[0];
    r.tank_burn        = fuel_sum[0];
    r.tank_idle_burn   = waste_sum[0];
    r.trip_distance    = distance_sum[1];
    r.trip_burn        = fuel_sum[1];
    r.trip_idle_burn   = waste_sum[1];
    r.outing_distance  = distance_sum[2];
    r.outing_burn      = fuel_sum[2];
    r.outing_idle_burn = waste_sum[2];
    r.adjusted_flow    = flow[31:0];
    r.idle_throttle    = idle_pos;
    return r;
  endfunction

  task automatic compare_totals(out_item_t got, out_item_t want);
    string names [11] = '{"tank_distance", "tank_burn", "tank_idle_burn", "trip_distance",
                          "trip_burn", "trip_idle_burn", "outing_distance", "outing_burn",
                          "outing_idle_burn", "adjusted_flow", "idle_throttle"};
    logic [31:0] g [11];
    logic [31:0] w [11];
    g = '{got.tank_distance, got.tank_burn, got.tank_idle_burn, got.trip_distance,
          got.trip_burn, got.trip_idle_burn, got.outing_distance, got.outing_burn,
          got.outing_idle_burn, got.adjusted_flow, 32'(got.idle_throttle)};
    w = '{want.tank_distance, want.tank_burn, want.tank_idle_burn, want.trip_distance,
          want.trip_burn, want.trip_idle_burn, want.outing_distance, want.outing_burn,
          want.outing_idle_burn, want.adjusted_flow, 32'(want.idle_throttle)};
    for (int k = 0; k < 11; k++) begin
      if (g[k] !== w[k])
        report_mismatch($sformatf("result %0d %s: got %h want %h",
                                  result_count, names[k], g[k], w[k]));
    end
  endtask

  // checks each accepted result and drives the receiver stalls
  initial begin : result_checker
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_totals.size() == 0)
          report_mismatch($sformatf("result %0d arrived with none expected", result_count));
        else
          compare_totals(out_data_o, pending_totals.pop_front());
        result_count++;
      end
      if (stall > 0 && !quiet) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // entered and left in the time step of a rising edge
  task automatic send_sample(in_item_t s);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (!in_ready_o);
    pending_totals.push_back(accumulate_sample(s));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (BlockLatency) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [7:0] pct);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= pct;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    gain_pct = pct;
  endtask

  function automatic in_item_t directed_base();
    in_item_t s;
    s = '0;
    s.elapsed_ms     = 16'd1000;
    s.speed_valid    = 1'b1;
    s.speed_kmh      = 8'd50;
    s.engine_running = 1'b1;
    s.throttle_valid = 1'b1;
    s.throttle_raw   = 8'd100;
    s.status_valid   = 1'b1;
    s.flow_supported = 1'b1;
    s.flow_valid     = 1'b1;
    s.flow_raw       = 16'd2000;
    return s;
  endfunction

  // mostly complete readings so that steps reach the fuel path
  function automatic in_item_t random_sample();
    in_item_t s;
    bit whole;
    int unsigned thr;
    whole = chance(90);
    s.clear_trip_mask = (!whole || chance(5)) ? 3'($urandom) : 3'b000;
    s.elapsed_ms      = (whole && chance(70)) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
    s.speed_valid     = whole ? chance(97) : 1'($urandom);
    s.speed_kmh       = chance(25) ? 8'd0 : 8'($urandom);
    s.engine_running  = whole ? chance(95) : 1'($urandom);
    s.throttle_valid  = whole ? chance(95) : 1'($urandom);
    thr = idle_pos + $urandom_range(0, 7);
    if (thr > 255) thr = 255;
    if (chance(40)) s.throttle_raw = 8'(thr);
    else if (chance(15)) s.throttle_raw = 8'd0;
    else s.throttle_raw = 8'($urandom);
    s.status_valid    = whole ? chance(95) : 1'($urandom);
    s.status_word     = 16'($urandom);
    s.flow_supported  = whole ? chance(95) : 1'($urandom);
    s.flow_valid      = whole ? chance(95) : 1'($urandom);
    s.flow_raw        = 16'($urandom);
    return s;
  endfunction

  function automatic logic [7:0] random_gain();
    if (chance(30)) return chance(50) ? 8'd0 : 8'd255;
    return 8'($urandom);
  endfunction

  task automatic test_directed_cases();
    in_item_t s;
    s = '0;
    send_sample(s);
    // every bit high: idle still 255, so open loop means cut-off
    s = '1;
    send_sample(s);
    s.clear_trip_mask = '0;
    s.status_word = ~OpenLoopMask;
    send_sample(s);
    s.speed_kmh = '0;
    send_sample(s);
    s = directed_base();
    s.engine_running = 1'b0;
    send_sample(s);
    s = directed_base();
    s.throttle_valid = 1'b0;
    send_sample(s);
    // zero throttle byte leaves the idle position alone
    s = directed_base();
    s.throttle_raw = 8'd0;
    send_sample(s);
    s.throttle_raw = 8'd20;
    send_sample(s);
    s.status_valid = 1'b0;
    send_sample(s);
    s = directed_base();
    s.status_word = OpenLoopMask;
    s.throttle_raw = 8'd23;
    send_sample(s);
    s.throttle_raw = 8'd24;
    send_sample(s);
    // new idle is taken before the cut-off test
    s.throttle_raw = 8'd10;
    send_sample(s);
    s = directed_base();
    s.flow_supported = 1'b0;
    send_sample(s);
    s = directed_base();
    s.flow_valid = 1'b0;
    send_sample(s);
    s = directed_base();
    s.elapsed_ms = '0;
    send_sample(s);
    s = directed_base();
    s.speed_kmh = '0;
    s.engine_running = 1'b0;
    send_sample(s);
    for (int k = 0; k < TripCount; k++) begin
      s = directed_base();
      s.clear_trip_mask = 3'b001 << k;
      send_sample(s);
    end
  endtask

  task automatic test_gain_settings();
    in_item_t s;
    logic [7:0] gains [5];
    gains = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd100};
    foreach (gains[k]) begin
      drain_results();
      write_gain(gains[k]);
      s = directed_base();
      s.flow_raw = '1;
      s.elapsed_ms = '1;
      s.speed_kmh = '0;
      send_sample(s);
      repeat (6) send_sample(random_sample());
    end
  endtask

  task automatic test_sum_wrap();
    in_item_t s;
    drain_results();
    write_gain(8'd255);
    quiet = 1'b1;
    // largest fuel step while stationary wraps fuel and idle fuel
    s = directed_base();
    s.clear_trip_mask = '1;
    s.speed_kmh = '0;
    s.elapsed_ms = '1;
    s.flow_raw = '1;
    send_sample(s);
    s.clear_trip_mask = '0;
    repeat (450) send_sample(s);
    quiet = 1'b0;
  endtask

  task automatic test_random_traffic();
    for (int seg = 0; seg < 6; seg++) begin
      drain_results();
      if (chance(70)) write_gain(random_gain());
      quiet = chance(25);
      repeat (250) send_sample(random_sample());
    end
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    for (int i = 0; i < TripCount; i++) begin
      distance_sum[i] = '0;
      fuel_sum[i] = '0;
      waste_sum[i] = '0;
    end
    idle_pos = 8'd255;
    gain_pct = 8'd100;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_gain_settings();
    test_sum_wrap();
    test_random_traffic();
    drain_results();
    if (pending_totals.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_totals.size()));
    if (mismatch_count == 0) begin
      $display("trip_fuel_distance_accumulator_top test passed");
    end else begin
      $display("trip_fuel_distance_accumulator_top test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tfda_pkg.sv
hdl/tfda_mul.sv
hdl/tfda_bank.sv
hdl/trip_fuel_distance_accumulator_top.sv
hdl/tfda_checker.sv
tb/tb_trip_fuel_distance_accumulator_top.sv
